>>> rtl/core/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
package lsc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DELTA_WIDTH = COORD_WIDTH + 1;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int FRAC_BITS   = 16;
    localparam int UFRAC_WIDTH = FRAC_BITS + 1;
    localparam int PROD_WIDTH  = UFRAC_WIDTH + 1 + DELTA_WIDTH;
    localparam int NUM_EDGES   = 4;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DELTA_WIDTH-1:0] t_delta;
    typedef logic [MAG_WIDTH-1:0]          t_mag;
    typedef logic [UFRAC_WIDTH-1:0]        t_ufrac;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;

    localparam t_ufrac UFRAC_ONE = t_ufrac'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_word;

    typedef struct packed {
        logic   visible;
        t_coord clip_start_x;
        t_coord clip_start_y;
        t_coord clip_end_x;
        t_coord clip_end_y;
    } t_out_word;

    typedef struct packed {
        logic pzero;
        logic pneg;
        logic qneg;
    } t_edge;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_delta dx;
        t_delta dy;
        t_edge [NUM_EDGES-1:0] edges;
    } t_side;

    typedef struct packed {
        logic   vis;
        t_ufrac u1;
        t_ufrac u2;
        t_coord x1;
        t_coord y1;
        t_delta dx;
        t_delta dy;
    } t_clip;

    typedef struct packed {
        t_coord window_left;
        t_coord window_right;
        t_coord window_bottom;
        t_coord window_top;
    } t_window;

endpackage

>>> rtl/core/lsc_front.sv
// Entry stage: deltas, boundary numerators and denominators.
module lsc_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  lsc_pkg::t_in_word       i_word,
    input  lsc_pkg::t_window        i_win,
    output logic                    o_valid,
    output lsc_pkg::t_side          o_side,
    output lsc_pkg::t_mag [3:0]     o_num,
    output lsc_pkg::t_mag [3:0]     o_den
);
    import lsc_pkg::*;

    t_delta n_p [NUM_EDGES];
    t_delta n_q [NUM_EDGES];
    t_delta n_dx;
    t_delta n_dy;
    t_delta x1;
    t_delta y1;
    t_side  n_side;
    t_mag [3:0] n_num;
    t_mag [3:0] n_den;
    logic   r_valid;
    t_side  r_side;
    t_mag [3:0] r_num;
    t_mag [3:0] r_den;

    always_comb begin
        x1   = DELTA_WIDTH'(i_word.start_x);
        y1   = DELTA_WIDTH'(i_word.start_y);
        n_dx = DELTA_WIDTH'(i_word.end_x) - x1;
        n_dy = DELTA_WIDTH'(i_word.end_y) - y1;
        n_p[0] = -n_dx;
        n_q[0] = x1 - DELTA_WIDTH'(i_win.window_left);
        n_p[1] = n_dx;
        n_q[1] = DELTA_WIDTH'(i_win.window_right) - x1;
        n_p[2] = -n_dy;
        n_q[2] = y1 - DELTA_WIDTH'(i_win.window_bottom);
        n_p[3] = n_dy;
        n_q[3] = DELTA_WIDTH'(i_win.window_top) - y1;
        n_side.x1 = i_word.start_x;
        n_side.y1 = i_word.start_y;
        n_side.dx = n_dx;
        n_side.dy = n_dy;
        for (int e = 0; e < NUM_EDGES; e++) begin
            n_side.edges[e].pzero = (n_p[e] == '0);
            n_side.edges[e].pneg  = n_p[e][DELTA_WIDTH-1];
            n_side.edges[e].qneg  = n_q[e][DELTA_WIDTH-1];
            n_num[e] = t_mag'(n_q[e][DELTA_WIDTH-1] ? -n_q[e] : n_q[e]);
            n_den[e] = t_mag'(n_p[e][DELTA_WIDTH-1] ? -n_p[e] : n_p[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_num  <= n_num;
            r_den  <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

>>> rtl/core/lsc_div.sv
// Pipelined unsigned divider, one quotient bit per stage, saturating.
module lsc_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  lsc_pkg::t_mag   i_num,
    input  lsc_pkg::t_mag   i_den,
    output lsc_pkg::t_ufrac o_quo,
    output logic            o_sat
);
    import lsc_pkg::*;

    logic [MAG_WIDTH:0] r_rem [0:FRAC_BITS];
    t_mag               r_den [0:FRAC_BITS];
    t_ufrac             r_quo [0:FRAC_BITS];
    logic               r_sat [0:FRAC_BITS];
    logic [MAG_WIDTH:0] n_rem [0:FRAC_BITS];
    t_ufrac             n_quo [0:FRAC_BITS];
    logic               n_sat [0:FRAC_BITS];
    logic [MAG_WIDTH:0] dbl;
    logic               ge;

    always_comb begin
        ge       = (i_num >= i_den);
        n_sat[0] = ({1'b0, i_num} >= {i_den, 1'b0});
        n_rem[0] = {1'b0, ge ? (i_num - i_den) : i_num};
        n_quo[0] = {{FRAC_BITS{1'b0}}, ge};
        dbl      = '0;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            dbl      = {r_rem[k-1][MAG_WIDTH-1:0], 1'b0};
            ge       = (dbl >= {1'b0, r_den[k-1]});
            n_rem[k] = ge ? (dbl - {1'b0, r_den[k-1]}) : dbl;
            n_quo[k] = {r_quo[k-1][UFRAC_WIDTH-2:0], ge};
            n_sat[k] = r_sat[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int k = 1; k <= FRAC_BITS; k++) begin
                r_den[k] <= r_den[k-1];
            end
            for (int k = 0; k <= FRAC_BITS; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_sat[k] <= n_sat[k];
            end
        end
    end

    assign o_quo = r_quo[FRAC_BITS];
    assign o_sat = r_sat[FRAC_BITS];

endmodule

>>> rtl/core/lsc_select.sv
// Boundary tests: visibility and entry/exit parameters.
module lsc_select (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  lsc_pkg::t_side        i_side,
    input  lsc_pkg::t_ufrac [3:0] i_quo,
    input  logic [3:0]            i_sat,
    output logic                  o_valid,
    output lsc_pkg::t_clip        o_clip
);
    import lsc_pkg::*;

    t_clip  n_clip;
    t_clip  r_clip;
    logic   r_valid;
    logic   rneg;
    logic   neg;
    logic   big;
    t_ufrac m;

    always_comb begin
        n_clip.vis = 1'b1;
        n_clip.u1  = '0;
        n_clip.u2  = UFRAC_ONE;
        n_clip.x1  = i_side.x1;
        n_clip.y1  = i_side.y1;
        n_clip.dx  = i_side.dx;
        n_clip.dy  = i_side.dy;
        rneg = 1'b0;
        neg  = 1'b0;
        big  = 1'b0;
        m    = '0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            rneg = i_side.edges[e].pneg ^ i_side.edges[e].qneg;
            m    = i_quo[e];
            neg  = rneg & (i_sat[e] | (m != '0));
            big  = !rneg & i_sat[e];
            if (i_side.edges[e].pzero) begin
                if (i_side.edges[e].qneg) n_clip.vis = 1'b0;
            end else if (i_side.edges[e].pneg) begin
                if (big) begin
                    n_clip.vis = 1'b0;
                end else if (!neg) begin
                    if (m > n_clip.u2) n_clip.vis = 1'b0;
                    else if (m > n_clip.u1) n_clip.u1 = m;
                end
            end else begin
                if (neg) begin
                    n_clip.vis = 1'b0;
                end else if (!big) begin
                    if (m < n_clip.u1) n_clip.vis = 1'b0;
                    else if (m < n_clip.u2) n_clip.u2 = m;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clip <= n_clip;
        end
    end

    assign o_valid = r_valid;
    assign o_clip  = r_clip;

endmodule

>>> rtl/core/lsc_back.sv
// Endpoint stages: u times delta, then floor scale and offset.
module lsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  lsc_pkg::t_clip      i_clip,
    output logic                o_valid,
    output lsc_pkg::t_out_word  o_word
);
    import lsc_pkg::*;

    t_prod     r_prod [4];
    t_prod     n_prod [4];
    logic      r_vis;
    t_coord    r_x1;
    t_coord    r_y1;
    logic      r_mvalid;
    logic      r_ovalid;
    t_out_word r_word;
    t_out_word n_word;
    t_coord    n_coord [4];

    always_comb begin
        n_prod[0] = t_prod'($signed({1'b0, i_clip.u1})) * t_prod'(i_clip.dx);
        n_prod[1] = t_prod'($signed({1'b0, i_clip.u1})) * t_prod'(i_clip.dy);
        n_prod[2] = t_prod'($signed({1'b0, i_clip.u2})) * t_prod'(i_clip.dx);
        n_prod[3] = t_prod'($signed({1'b0, i_clip.u2})) * t_prod'(i_clip.dy);
        for (int k = 0; k < 4; k++) begin
            n_coord[k] = t_coord'(r_prod[k] >>> FRAC_BITS)
                       + (k[0] ? r_y1 : r_x1);
        end
        n_word.visible      = r_vis;
        n_word.clip_start_x = r_vis ? n_coord[0] : '0;
        n_word.clip_start_y = r_vis ? n_coord[1] : '0;
        n_word.clip_end_x   = r_vis ? n_coord[2] : '0;
        n_word.clip_end_y   = r_vis ? n_coord[3] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (i_en) begin
            r_mvalid <= i_valid;
            r_ovalid <= r_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_vis  <= i_clip.vis;
            r_x1   <= i_clip.x1;
            r_y1   <= i_clip.y1;
            r_word <= n_word;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_word;

endmodule

>>> rtl/core/line_segment_clipper.sv
// Line segment clipper top level: Liang-Barsky clip against a window.
//
//  channel | valid       | stall       | data
//  --------+-------------+-------------+--------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_word  (segment)
//  out     | o_out_valid | i_out_stall | o_out_word (clipped)
//  cfg     | i_cfg_we    | -           | i_cfg_idx, i_cfg_data
//
// One word per cycle while the output is not stalled. Stages in order: entry,
// the 17-stage quotient pipelines (one quotient bit per stage), test, multiply
// and output. The whole pipeline holds while the output word is stalled.
// Synchronous reset clears valid bits and loads the default window.
module line_segment_clipper (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  lsc_pkg::t_in_word                      i_in_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output lsc_pkg::t_out_word                     o_out_word,
    input  logic                                   i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [lsc_pkg::COORD_WIDTH-1:0]        i_cfg_data
);
    import lsc_pkg::*;

    localparam int DLY = FRAC_BITS + 1;

    logic          adv;
    t_window       r_win;
    logic          f_valid;
    t_side         f_side;
    t_mag [3:0]    f_num;
    t_mag [3:0]    f_den;
    t_ufrac [3:0]  d_quo;
    logic [3:0]    d_sat;
    t_side         r_side [0:DLY-1];
    logic          r_vld  [0:DLY-1];
    logic          s_valid;
    t_clip         s_clip;

    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.window_left   <= -t_coord'(8192);
            r_win.window_right  <= t_coord'(8192);
            r_win.window_bottom <= -t_coord'(8192);
            r_win.window_top    <= t_coord'(8192);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LEFT:   r_win.window_left   <= i_cfg_data;
                REG_RIGHT:  r_win.window_right  <= i_cfg_data;
                REG_BOTTOM: r_win.window_bottom <= i_cfg_data;
                REG_TOP:    r_win.window_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_win   (r_win),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
        lsc_div u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (f_num[e]),
            .i_den (f_den[e]),
            .o_quo (d_quo[e]),
            .o_sat (d_sat[e])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= f_valid;
            for (int k = 1; k < DLY; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= f_side;
            for (int k = 1; k < DLY; k++) r_side[k] <= r_side[k-1];
        end
    end

    lsc_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_vld[DLY-1]),
        .i_side  (r_side[DLY-1]),
        .i_quo   (d_quo),
        .i_sat   (d_sat),
        .o_valid (s_valid),
        .o_clip  (s_clip)
    );

    lsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (s_valid),
        .i_clip  (s_clip),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule
